@@ hdl/rm2eul_pkg.sv @@
// Shared constants and the arctangent step table for the Euler angle converter.
`default_nettype none
package rm2eul_pkg;

   localparam int CORDIC_STAGES = 30;
   localparam int SQRT_STEPS    = 32;
   localparam int GUARD_BITS    = 8;
   localparam int CW            = 44;   // CORDIC x/y datapath width
   localparam int ZW            = 34;   // CORDIC angle accumulator width
   localparam int THR_W         = 29;

   localparam int FRONT_DEPTH    = 3;   // abs, square, sum
   localparam int ALIGN_DEPTH    = FRONT_DEPTH + SQRT_STEPS;
   localparam int CORDIC_LATENCY = CORDIC_STAGES + 2;
   localparam int LATENCY        = 1 + ALIGN_DEPTH + CORDIC_LATENCY + 2;

   localparam logic signed [ZW-1:0] PI_Q29         = 34'sd1686629713;
   localparam logic signed [ZW-1:0] HALF_PI_Q29    = 34'sd843314857;
   localparam logic signed [ZW-1:0] QUARTER_PI_Q29 = 34'sd421657428;
   localparam logic [THR_W-1:0]     LOCK_RESET     = 29'd537;

   // atan(2^-i) in Q5.29, from the alternating series in Q62
   function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
      logic [63:0] acc;
      logic [63:0] rnd;
      acc = 64'd0;
      if (i == 0) begin
         return QUARTER_PI_Q29;
      end
      if (i * 1 <= 62)  acc = acc + ((64'd1 << (62 - i * 1))  / 64'd1);
      if (i * 3 <= 62)  acc = acc - ((64'd1 << (62 - i * 3))  / 64'd3);
      if (i * 5 <= 62)  acc = acc + ((64'd1 << (62 - i * 5))  / 64'd5);
      if (i * 7 <= 62)  acc = acc - ((64'd1 << (62 - i * 7))  / 64'd7);
      if (i * 9 <= 62)  acc = acc + ((64'd1 << (62 - i * 9))  / 64'd9);
      if (i * 11 <= 62) acc = acc - ((64'd1 << (62 - i * 11)) / 64'd11);
      if (i * 13 <= 62) acc = acc + ((64'd1 << (62 - i * 13)) / 64'd13);
      if (i * 15 <= 62) acc = acc - ((64'd1 << (62 - i * 15)) / 64'd15);
      if (i * 17 <= 62) acc = acc + ((64'd1 << (62 - i * 17)) / 64'd17);
      if (i * 19 <= 62) acc = acc - ((64'd1 << (62 - i * 19)) / 64'd19);
      if (i * 21 <= 62) acc = acc + ((64'd1 << (62 - i * 21)) / 64'd21);
      if (i * 23 <= 62) acc = acc - ((64'd1 << (62 - i * 23)) / 64'd23);
      if (i * 25 <= 62) acc = acc + ((64'd1 << (62 - i * 25)) / 64'd25);
      if (i * 27 <= 62) acc = acc - ((64'd1 << (62 - i * 27)) / 64'd27);
      if (i * 29 <= 62) acc = acc + ((64'd1 << (62 - i * 29)) / 64'd29);
      if (i * 31 <= 62) acc = acc - ((64'd1 << (62 - i * 31)) / 64'd31);
      if (i * 33 <= 62) acc = acc + ((64'd1 << (62 - i * 33)) / 64'd33);
      if (i * 35 <= 62) acc = acc - ((64'd1 << (62 - i * 35)) / 64'd35);
      if (i * 37 <= 62) acc = acc + ((64'd1 << (62 - i * 37)) / 64'd37);
      if (i * 39 <= 62) acc = acc - ((64'd1 << (62 - i * 39)) / 64'd39);
      if (i * 41 <= 62) acc = acc + ((64'd1 << (62 - i * 41)) / 64'd41);
      if (i * 43 <= 62) acc = acc - ((64'd1 << (62 - i * 43)) / 64'd43);
      if (i * 45 <= 62) acc = acc + ((64'd1 << (62 - i * 45)) / 64'd45);
      if (i * 47 <= 62) acc = acc - ((64'd1 << (62 - i * 47)) / 64'd47);
      if (i * 49 <= 62) acc = acc + ((64'd1 << (62 - i * 49)) / 64'd49);
      if (i * 51 <= 62) acc = acc - ((64'd1 << (62 - i * 51)) / 64'd51);
      if (i * 53 <= 62) acc = acc + ((64'd1 << (62 - i * 53)) / 64'd53);
      if (i * 55 <= 62) acc = acc - ((64'd1 << (62 - i * 55)) / 64'd55);
      if (i * 57 <= 62) acc = acc + ((64'd1 << (62 - i * 57)) / 64'd57);
      if (i * 59 <= 62) acc = acc - ((64'd1 << (62 - i * 59)) / 64'd59);
      if (i * 61 <= 62) acc = acc + ((64'd1 << (62 - i * 61)) / 64'd61);
      rnd = (acc + 64'h1_0000_0000) >> 33;
      return signed'(ZW'(rnd));
   endfunction

endpackage
`default_nettype wire

@@ hdl/rotation_matrix_to_euler_angles.sv @@
// Top level: ZYX roll, pitch and yaw from a rotation matrix, fully pipelined.
//
//  channel   ports                                  handshake
//  request   req_r00..req_r22 (s32 Q2.30)           start, busy (tied low)
//  response  rsp_roll/pitch/yaw_angle, rsp_gimbal_lock   rsp_valid, one cycle
//  control   csr_wdata (u29 lock window, Q0.29)     csr_we
//
// One matrix enters every cycle; the LATENCY from start to result is set by the
// 32-step square root followed by the pitch CORDIC chain. Roll and yaw CORDICs run
// alongside and are delayed to match.
// Reset clears the valid line and loads the lock window with its default.
// Nothing stalls: busy stays low and every transaction flows straight through.
`default_nettype none
module rotation_matrix_to_euler_angles (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_r00,
   input  wire logic signed [31:0] req_r01,
   input  wire logic signed [31:0] req_r10,
   input  wire logic signed [31:0] req_r11,
   input  wire logic signed [31:0] req_r20,
   input  wire logic signed [31:0] req_r21,
   input  wire logic signed [31:0] req_r22,
   input  wire logic               csr_we,
   input  wire logic [28:0]        csr_wdata,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_roll_angle,
   output logic signed [30:0]      rsp_pitch_angle,
   output logic signed [31:0]      rsp_yaw_angle,
   output logic                    rsp_gimbal_lock
);

   localparam int LAT   = rm2eul_pkg::LATENCY;
   localparam int ALIGN = rm2eul_pkg::ALIGN_DEPTH;

   logic                           valid_ff [LAT];
   logic [rm2eul_pkg::THR_W-1:0]   thr_ff;

   logic signed [31:0] r00_ff, r01_ff, r10_ff, r11_ff, r20_ff, r21_ff, r22_ff;
   logic [31:0]        abs00_ff, abs10_ff;
   logic [63:0]        sq00_ff, sq10_ff;
   logic [63:0]        sum_ff;
   logic [31:0]        root;

   logic signed [32:0] negr20_ff [ALIGN];
   logic signed [31:0] yawa_ff [ALIGN+1];
   logic signed [31:0] yawb_ff [ALIGN+1];
   logic signed [31:0] roll_ff [ALIGN+1];

   logic signed [31:0] yawa_angle, yawb_angle, roll_angle, pitch_angle;
   logic signed [30:0] pitchc_ff;
   logic signed [30:0] pitchc_in;
   logic signed [30:0] pitch_mag;
   logic [30:0]        gap;
   logic               locked;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= rm2eul_pkg::LOCK_RESET;
         for (int k = 0; k < LAT; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         valid_ff[0] <= start & ~busy;
         for (int k = 1; k < LAT; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // front end: capture, magnitudes, squares, sum
   always_ff @(posedge clock) begin
      r00_ff   <= req_r00;
      r01_ff   <= req_r01;
      r10_ff   <= req_r10;
      r11_ff   <= req_r11;
      r20_ff   <= req_r20;
      r21_ff   <= req_r21;
      r22_ff   <= req_r22;
      abs00_ff <= (r00_ff < 0) ? 32'(-r00_ff) : 32'(r00_ff);
      abs10_ff <= (r10_ff < 0) ? 32'(-r10_ff) : 32'(r10_ff);
      sq00_ff  <= 64'(abs00_ff) * 64'(abs00_ff);
      sq10_ff  <= 64'(abs10_ff) * 64'(abs10_ff);
      sum_ff   <= sq00_ff + sq10_ff;
   end

   rm2eul_sqrt u_sqrt (
      .clock    (clock),
      .in_value (sum_ff),
      .out_root (root)
   );

   rm2eul_cordic u_yawa (
      .clock     (clock),
      .in_y      (33'(r10_ff)),
      .in_x      (33'(r00_ff)),
      .out_angle (yawa_angle)
   );

   rm2eul_cordic u_yawb (
      .clock     (clock),
      .in_y      (-(33'(r01_ff))),
      .in_x      (33'(r11_ff)),
      .out_angle (yawb_angle)
   );

   rm2eul_cordic u_roll (
      .clock     (clock),
      .in_y      (33'(r21_ff)),
      .in_x      (33'(r22_ff)),
      .out_angle (roll_angle)
   );

   rm2eul_cordic u_pitch (
      .clock     (clock),
      .in_y      (negr20_ff[ALIGN-1]),
      .in_x      ({1'b0, root}),
      .out_angle (pitch_angle)
   );

   // hold side results until the pitch path catches up
   always_ff @(posedge clock) begin
      negr20_ff[0] <= -(33'(r20_ff));
      for (int k = 1; k < ALIGN; k++) begin
         negr20_ff[k] <= negr20_ff[k-1];
      end
      yawa_ff[0] <= yawa_angle;
      yawb_ff[0] <= yawb_angle;
      roll_ff[0] <= roll_angle;
      for (int k = 1; k <= ALIGN; k++) begin
         yawa_ff[k] <= yawa_ff[k-1];
         yawb_ff[k] <= yawb_ff[k-1];
         roll_ff[k] <= roll_ff[k-1];
      end
   end

   always_comb begin
      if (pitch_angle > 32'(rm2eul_pkg::HALF_PI_Q29)) begin
         pitchc_in = 31'(rm2eul_pkg::HALF_PI_Q29);
      end else if (pitch_angle < -32'(rm2eul_pkg::HALF_PI_Q29)) begin
         pitchc_in = -31'(rm2eul_pkg::HALF_PI_Q29);
      end else begin
         pitchc_in = 31'(pitch_angle);
      end
   end

   always_ff @(posedge clock) begin
      pitchc_ff <= pitchc_in;
   end

   always_comb begin
      pitch_mag = (pitchc_ff < 0) ? -pitchc_ff : pitchc_ff;
      gap       = 31'(rm2eul_pkg::HALF_PI_Q29) - 31'(pitch_mag);
      locked    = !(gap > 31'(thr_ff));
   end

   always_ff @(posedge clock) begin
      rsp_pitch_angle <= pitchc_ff;
      rsp_gimbal_lock <= locked;
      rsp_yaw_angle   <= locked ? yawb_ff[ALIGN] : yawa_ff[ALIGN];
      rsp_roll_angle  <= locked ? 32'sd0 : roll_ff[ALIGN];
   end

   assign rsp_valid = valid_ff[LAT-1];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(rm2eul_pkg::LATENCY) rsp_valid)
      else $error("accepted transaction did not complete on time");

   a_lock_roll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gimbal_lock |-> rsp_roll_angle == 32'sd0)
      else $error("roll not zero under gimbal lock");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 31'sd843314857)
                    && (rsp_pitch_angle >= -31'sd843314857))
      else $error("pitch outside half pi");

endmodule
`default_nettype wire

@@ hdl/rm2eul_sqrt.sv @@
// Pipelined bit-pair integer square root of a 64-bit sum of squares.
`default_nettype none
module rm2eul_sqrt (
   input  wire logic        clock,
   input  wire logic [63:0] in_value,
   output logic      [31:0] out_root
);

   localparam int N = rm2eul_pkg::SQRT_STEPS;

   logic [63:0] rem_ff [N];
   logic [63:0] res_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] rem_prev;
      logic [63:0] res_prev;
      logic [63:0] trial;
      logic [63:0] rem_in;
      logic [63:0] res_in;

      if (k == 0) begin : g_first
         assign rem_prev = in_value;
         assign res_prev = 64'd0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
      end

      always_comb begin
         trial = res_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         res_ff[k] <= res_in;
      end
   end

   assign out_root = res_ff[N-1][31:0];

endmodule
`default_nettype wire

@@ hdl/rm2eul_cordic.sv @@
// Pipelined vectoring CORDIC atan2 with quadrant fold and output clamp.
`default_nettype none
module rm2eul_cordic (
   input  wire logic               clock,
   input  wire logic signed [32:0] in_y,
   input  wire logic signed [32:0] in_x,
   output logic signed      [31:0] out_angle
);

   localparam int S  = rm2eul_pkg::CORDIC_STAGES;
   localparam int CW = rm2eul_pkg::CW;
   localparam int ZW = rm2eul_pkg::ZW;

   logic signed [CW-1:0] x_ff [S+1];
   logic signed [CW-1:0] y_ff [S+1];
   logic signed [ZW-1:0] z_ff [S+1];
   logic                 zero_ff [S+1];
   logic                 xneg_ff [S+1];

   logic signed [CW-1:0] xe;
   logic signed [CW-1:0] ye;
   logic                 xneg;
   logic signed [ZW-1:0] angle_in;
   logic signed [31:0]   angle_ff;

   // fold the left half plane onto the right, start from +-pi
   always_comb begin
      xe   = CW'(in_x);
      ye   = CW'(in_y);
      xneg = in_x < 0;
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= (xneg ? -xe : xe) <<< rm2eul_pkg::GUARD_BITS;
      y_ff[0]    <= (xneg ? -ye : ye) <<< rm2eul_pkg::GUARD_BITS;
      z_ff[0]    <= xneg ? ((in_y > 0) ? rm2eul_pkg::PI_Q29 : -rm2eul_pkg::PI_Q29)
                         : '0;
      zero_ff[0] <= in_y == 0;
      xneg_ff[0] <= xneg;
   end

   for (genvar i = 0; i < S; i++) begin : g_stage
      localparam logic signed [ZW-1:0] ANG = rm2eul_pkg::atan_step(i);
      logic signed [CW-1:0] x_in;
      logic signed [CW-1:0] y_in;
      logic signed [ZW-1:0] z_in;

      always_comb begin
         if (y_ff[i] > 0) begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + ANG;
         end else begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - ANG;
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i+1]    <= x_in;
         y_ff[i+1]    <= y_in;
         z_ff[i+1]    <= z_in;
         zero_ff[i+1] <= zero_ff[i];
         xneg_ff[i+1] <= xneg_ff[i];
      end
   end

   always_comb begin
      if (zero_ff[S]) begin
         angle_in = xneg_ff[S] ? rm2eul_pkg::PI_Q29 : '0;
      end else if (z_ff[S] > rm2eul_pkg::PI_Q29) begin
         angle_in = rm2eul_pkg::PI_Q29;
      end else if (z_ff[S] < -rm2eul_pkg::PI_Q29) begin
         angle_in = -rm2eul_pkg::PI_Q29;
      end else begin
         angle_in = z_ff[S];
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= 32'(angle_in);
   end

   assign out_angle = angle_ff;

endmodule
`default_nettype wire
